>>> rtl/lpw_pkg.sv
// Shared types for the line pixel walker.
`timescale 1ns / 1ps

package lpw_pkg;

  // Item kind carried on the input channel.
  typedef enum logic {
    MODE_START   = 1'b0,
    MODE_ADVANCE = 1'b1
  } lpw_mode_t;

  // Per-line orientation and the single-pixel flag from setup.
  typedef struct packed {
    logic x_is_major;
    logic minor_down;
    logic fin;
  } lpw_flags_t;

endpackage

>>> rtl/lpw_setup.sv
// Start-of-line setup: major axis, endpoint order, deltas and initial error.
`timescale 1ns / 1ps

module lpw_setup import lpw_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]   xa,
  input  logic [COORD_BITS-1:0]   ya,
  input  logic [COORD_BITS-1:0]   xb,
  input  logic [COORD_BITS-1:0]   yb,
  output logic [COORD_BITS-1:0]   first_x,
  output logic [COORD_BITS-1:0]   first_y,
  output logic [COORD_BITS-1:0]   major_end,
  output logic [COORD_BITS-1:0]   delta_major,
  output logic [COORD_BITS-1:0]   delta_minor,
  output logic [COORD_BITS+2:0]   error_init,
  output lpw_flags_t              flags
);

  localparam int EB = COORD_BITS + 3;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  xmaj;
  logic                  swap;
  logic [COORD_BITS-1:0] last_x;
  logic [COORD_BITS-1:0] last_y;
  logic [EB-1:0]         dmin_e;
  logic [EB-1:0]         dmaj_e;

  always_comb begin
    dx   = (xa > xb) ? (xa - xb) : (xb - xa);
    dy   = (ya > yb) ? (ya - yb) : (yb - ya);
    xmaj = (dx >= dy);
    // ties on the major coordinate keep the first endpoint first
    swap = xmaj ? (xa > xb) : (ya > yb);

    first_x = swap ? xb : xa;
    first_y = swap ? yb : ya;
    last_x  = swap ? xa : xb;
    last_y  = swap ? ya : yb;

    major_end   = xmaj ? last_x : last_y;
    delta_major = xmaj ? dx : dy;
    delta_minor = xmaj ? dy : dx;

    dmin_e     = {3'b000, delta_minor};
    dmaj_e     = {3'b000, delta_major};
    error_init = {dmin_e[EB-2:0], 1'b0} - dmaj_e;

    flags.x_is_major = xmaj;
    flags.minor_down = xmaj ? (last_y < first_y) : (last_x < first_x);
    flags.fin        = xmaj ? (first_x == last_x) : (first_y == last_y);
  end

endmodule

>>> rtl/lpw_core.sv
// Line state registers and the per-pixel Bresenham step.
`timescale 1ns / 1ps

module lpw_core import lpw_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  lpw_mode_t             mode,
  input  logic [COORD_BITS-1:0] first_x,
  input  logic [COORD_BITS-1:0] first_y,
  input  logic [COORD_BITS-1:0] major_end_in,
  input  logic [COORD_BITS-1:0] delta_major_in,
  input  logic [COORD_BITS-1:0] delta_minor_in,
  input  logic [COORD_BITS+2:0] error_init,
  input  lpw_flags_t            flags_in,
  output logic                  res_valid,
  output logic [COORD_BITS-1:0] res_x,
  output logic [COORD_BITS-1:0] res_y,
  output logic                  res_last
);

  localparam int EB = COORD_BITS + 3;

  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [EB-1:0]         decision_error;
  logic [COORD_BITS-1:0] delta_major;
  logic [COORD_BITS-1:0] delta_minor;
  logic [COORD_BITS-1:0] major_end;
  logic                  minor_down;
  logic                  x_is_major;
  logic                  busy;

  logic [COORD_BITS-1:0] cur_x_next;
  logic [COORD_BITS-1:0] cur_y_next;
  logic [EB-1:0]         decision_error_next;
  logic                  busy_next;

  logic                  step_minor;
  logic [COORD_BITS-1:0] major_cur;
  logic [COORD_BITS-1:0] minor_cur;
  logic [COORD_BITS-1:0] major_inc;
  logic [COORD_BITS-1:0] minor_new;
  logic [EB-1:0]         dmin_e;
  logic [EB-1:0]         dmaj_e;
  logic [EB-1:0]         diff_e;
  logic [EB-1:0]         err_add;
  logic                  adv_fin;

  always_comb begin
    step_minor = ~decision_error[EB-1];
    major_cur  = x_is_major ? cur_x : cur_y;
    minor_cur  = x_is_major ? cur_y : cur_x;
    major_inc  = major_cur + 1'b1;
    if (step_minor) begin
      minor_new = minor_down ? (minor_cur - 1'b1) : (minor_cur + 1'b1);
    end else begin
      minor_new = minor_cur;
    end
    dmin_e  = {3'b000, delta_minor};
    dmaj_e  = {3'b000, delta_major};
    diff_e  = dmin_e - dmaj_e;
    err_add = step_minor ? {diff_e[EB-2:0], 1'b0} : {dmin_e[EB-2:0], 1'b0};
    adv_fin = (major_inc == major_end);

    cur_x_next          = cur_x;
    cur_y_next          = cur_y;
    decision_error_next = decision_error;
    busy_next           = busy;
    res_valid           = 1'b0;
    res_x               = '0;
    res_y               = '0;
    res_last            = 1'b0;

    case (mode)
      MODE_START: begin
        cur_x_next          = first_x;
        cur_y_next          = first_y;
        decision_error_next = error_init;
        busy_next           = ~flags_in.fin;
        res_valid           = 1'b1;
        res_x               = first_x;
        res_y               = first_y;
        res_last            = flags_in.fin;
      end
      MODE_ADVANCE: begin
        if (busy) begin
          cur_x_next          = x_is_major ? major_inc : minor_new;
          cur_y_next          = x_is_major ? minor_new : major_inc;
          decision_error_next = decision_error + err_add;
          busy_next           = ~adv_fin;
          res_valid           = 1'b1;
          res_x               = cur_x_next;
          res_y               = cur_y_next;
          res_last            = adv_fin;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // only busy is control; the rest is rewritten by every start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (fire) begin
      busy <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur_x          <= cur_x_next;
      cur_y          <= cur_y_next;
      decision_error <= decision_error_next;
      if (mode == MODE_START) begin
        delta_major <= delta_major_in;
        delta_minor <= delta_minor_in;
        major_end   <= major_end_in;
        minor_down  <= flags_in.minor_down;
        x_is_major  <= flags_in.x_is_major;
      end
    end
  end

  // a final pixel always leaves the walker idle
  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res_last |=> !busy)
    else $error("walker still busy after last pixel");

  // line state only moves on a processed beat
  a_busy_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(busy))
    else $error("busy changed without a beat");

  // no pixel is flagged last unless it is a real pixel
  a_last_needs_valid: assert property (@(posedge clk) disable iff (rst)
    fire && !res_valid |-> !res_last)
    else $error("last set on an empty result");

endmodule

>>> rtl/line_pixel_walker.sv
// Top level: input skid register, line setup, step core and result register.
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// --------+----------------------+------------------------------------------
// input   | in_valid / in_stall  | mode, x_start, y_start, x_end, y_end
// output  | out_valid / out_stall| valid_res, pixel_x, pixel_y, last
//
// One beat in gives one beat out; a new beat is taken every cycle unless
// in_stall holds it. A beat passes the input register, then setup/step logic
// into the result register. The step is add/compare on the registered state.
// Reset (rst, synchronous) empties both registers and leaves the walker idle.
// in_stall rises only when the input register is full and the result
// register is held by out_stall, so one beat can wait in each stage.

module line_pixel_walker import lpw_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  valid_res,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last
);

  // input register
  logic                  s1_valid;
  lpw_mode_t             s1_mode;
  logic [COORD_BITS-1:0] s1_xa;
  logic [COORD_BITS-1:0] s1_ya;
  logic [COORD_BITS-1:0] s1_xb;
  logic [COORD_BITS-1:0] s1_yb;

  logic in_take;
  logic fire;

  // setup results
  logic [COORD_BITS-1:0] su_first_x;
  logic [COORD_BITS-1:0] su_first_y;
  logic [COORD_BITS-1:0] su_major_end;
  logic [COORD_BITS-1:0] su_delta_major;
  logic [COORD_BITS-1:0] su_delta_minor;
  logic [COORD_BITS+2:0] su_error_init;
  lpw_flags_t            su_flags;

  // core results
  logic                  res_valid;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  logic                  res_last;

  // the input stage drains whenever the result register is free or leaving
  assign fire     = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && !fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode <= lpw_mode_t'(mode);
      s1_xa   <= x_start;
      s1_ya   <= y_start;
      s1_xb   <= x_end;
      s1_yb   <= y_end;
    end
  end

  lpw_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .xa          (s1_xa),
    .ya          (s1_ya),
    .xb          (s1_xb),
    .yb          (s1_yb),
    .first_x     (su_first_x),
    .first_y     (su_first_y),
    .major_end   (su_major_end),
    .delta_major (su_delta_major),
    .delta_minor (su_delta_minor),
    .error_init  (su_error_init),
    .flags       (su_flags)
  );

  lpw_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .mode           (s1_mode),
    .first_x        (su_first_x),
    .first_y        (su_first_y),
    .major_end_in   (su_major_end),
    .delta_major_in (su_delta_major),
    .delta_minor_in (su_delta_minor),
    .error_init     (su_error_init),
    .flags_in       (su_flags),
    .res_valid      (res_valid),
    .res_x          (res_x),
    .res_y          (res_y),
    .res_last       (res_last)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      valid_res <= res_valid;
      pixel_x   <= res_x;
      pixel_y   <= res_y;
      last      <= res_last;
    end
  end

  // a stall upstream needs a beat parked in the input register
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // a queued beat reaches the result register when that register is empty
  a_out_from_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("queued beat did not reach the result register");

  // a waiting beat is not dropped while the output is held
  a_s1_kept: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid)
    else $error("input register lost a stalled beat");

endmodule
